// ===== rtl/pmt_pkg.sv =====
// shared types and constants for the ps2 mouse packet tracker
package pmt_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int SIZE_BITS      = 13;
    localparam int OUT_COORD_BITS = 12;
    localparam int QUEUE_DEPTH    = 2;
    localparam int APB_ADDR_BITS  = 4;

    localparam logic [7:0] SYNC_MASK   = 8'h08;
    localparam logic [7:0] X_OVF_MASK  = 8'h40;
    localparam logic [7:0] Y_OVF_MASK  = 8'h80;
    localparam logic [7:0] BUTTON_MASK = 8'h07;

    localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = 13'd800;
    localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = 13'd600;

    typedef enum logic [1:0] {
        REG_SCREEN_WIDTH  = 2'd0,
        REG_SCREEN_HEIGHT = 2'd1,
        REG_MOUSE_ENABLE  = 2'd2
    } reg_index_t;

    typedef enum logic [0:0] {
        REQ_DATA     = 1'b0,
        REQ_RECENTER = 1'b1
    } req_t;

    typedef enum logic [2:0] {
        OUT_IGNORED    = 3'd0,
        OUT_STORED     = 3'd1,
        OUT_APPLIED    = 3'd2,
        OUT_DROPPED    = 3'd3,
        OUT_RECENTERED = 3'd4
    } outcome_t;

    typedef enum logic [1:0] {
        POS_HEADER = 2'd0,
        POS_DX     = 2'd1,
        POS_DY     = 2'd2
    } pos_t;

    typedef struct packed {
        logic [SIZE_BITS-1:0] screen_width;
        logic [SIZE_BITS-1:0] screen_height;
        logic                 mouse_enable;
    } cfg_t;

    typedef struct packed {
        outcome_t   outcome;
        logic [7:0] dx;
        logic [7:0] dy;
        logic [2:0] buttons;
    } cmd_t;

endpackage

// ===== rtl/pmt_front.sv =====
// front end: packet assembly and classification of each transaction
module pmt_front import pmt_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       accept,
    input  logic       req_type,
    input  logic [7:0] data_byte,
    output cmd_t       cmd
);

    pos_t       pos_reg, pos_next;
    logic [7:0] header_reg, header_next;
    logic [7:0] dx_reg, dx_next;

    always_comb begin
        pos_next = pos_reg;
        if (req_t'(req_type) == REQ_RECENTER) begin
            pos_next = POS_HEADER;
        end else if (cfg.mouse_enable) begin
            case (pos_reg)
                POS_HEADER: pos_next = ((data_byte & SYNC_MASK) != 8'h00) ? POS_DX : POS_HEADER;
                POS_DX:     pos_next = POS_DY;
                POS_DY:     pos_next = POS_HEADER;
                default:    pos_next = ((data_byte & SYNC_MASK) != 8'h00) ? POS_DX : POS_HEADER;
            endcase
        end
    end

    always_comb begin
        header_next = header_reg;
        dx_next     = dx_reg;
        cmd.outcome = OUT_IGNORED;
        cmd.dx      = dx_reg;
        cmd.dy      = data_byte;
        cmd.buttons = 3'(header_reg & BUTTON_MASK);
        if (req_t'(req_type) == REQ_RECENTER) begin
            cmd.outcome = OUT_RECENTERED;
        end else if (cfg.mouse_enable) begin
            case (pos_reg)
                POS_DX: begin
                    dx_next     = data_byte;
                    cmd.outcome = OUT_STORED;
                end
                POS_DY: begin
                    if ((header_reg & (X_OVF_MASK | Y_OVF_MASK)) != 8'h00) begin
                        cmd.outcome = OUT_DROPPED;
                    end else begin
                        cmd.outcome = OUT_APPLIED;
                    end
                end
                default: begin
                    if ((data_byte & SYNC_MASK) != 8'h00) begin
                        header_next = data_byte;
                        cmd.outcome = OUT_STORED;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= POS_HEADER;
            header_reg <= 8'h00;
            dx_reg     <= 8'h00;
        end else if (accept) begin
            pos_reg    <= pos_next;
            header_reg <= header_next;
            dx_reg     <= dx_next;
        end
    end

endmodule

// ===== rtl/pmt_queue.sv =====
// short command queue between front and back
module pmt_queue import pmt_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t pop_cmd
);

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(QUEUE_DEPTH - 1);
    localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(QUEUE_DEPTH);

    cmd_t                entry_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;

    assign full      = (count_reg == DEPTH_CNT);
    assign not_empty = (count_reg != '0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_CNT)
        else $error("queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("pop from empty queue");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("push into full queue");

endmodule

// ===== rtl/pmt_back.sv =====
// back end: cursor update, clamping and result register
module pmt_back import pmt_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cfg_t                      cfg,
    input  logic                      cmd_valid,
    input  cmd_t                      cmd,
    output logic                      cmd_take,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [OUT_COORD_BITS-1:0] m_cursor_x_out,
    output logic [OUT_COORD_BITS-1:0] m_cursor_y_out,
    output logic [2:0]                m_buttons_out,
    output logic [2:0]                m_outcome
);

    localparam int CMAX = (1 << COORD_BITS) - 1;
    localparam logic [15:0] CMAX16 = 16'(CMAX);
    localparam int RESET_X = (400 > CMAX) ? CMAX : 400;
    localparam int RESET_Y = (300 > CMAX) ? CMAX : 300;
    localparam int VBITS = COORD_BITS + 2;

    function automatic logic [COORD_BITS-1:0] limit_of(input logic [SIZE_BITS-1:0] size);
        logic [SIZE_BITS-1:0] s;
        logic [SIZE_BITS-1:0] m;
        s = (size == '0) ? SIZE_BITS'(1) : size;
        m = s - 1'b1;
        return (16'(m) > CMAX16) ? COORD_BITS'(CMAX) : COORD_BITS'(m);
    endfunction

    function automatic logic [COORD_BITS-1:0] centre_of(input logic [SIZE_BITS-1:0] size);
        logic [SIZE_BITS-1:0] s;
        logic [SIZE_BITS-1:0] c;
        s = (size == '0) ? SIZE_BITS'(1) : size;
        c = s >> 1;
        return (16'(c) > CMAX16) ? COORD_BITS'(CMAX) : COORD_BITS'(c);
    endfunction

    function automatic logic [COORD_BITS-1:0] move_clamped(
        input logic [COORD_BITS-1:0] pos,
        input logic signed [9:0]     delta,
        input logic [COORD_BITS-1:0] lim
    );
        logic signed [VBITS-1:0] v;
        v = signed'({2'b00, pos}) + VBITS'(delta);
        if (v < 0) begin
            return '0;
        end
        if ((COORD_BITS+1)'(v) > {1'b0, lim}) begin
            return lim;
        end
        return COORD_BITS'(v);
    endfunction

    logic [COORD_BITS-1:0] cursor_x_reg, cursor_x_next;
    logic [COORD_BITS-1:0] cursor_y_reg, cursor_y_next;
    logic [2:0]            buttons_reg, buttons_next;
    logic                  m_valid_reg;
    outcome_t              outcome_reg;
    logic signed [9:0]     delta_x;
    logic signed [9:0]     delta_y;

    assign cmd_take = cmd_valid && (!m_valid_reg || m_ready);
    assign delta_x  = 10'(signed'(cmd.dx));
    assign delta_y  = -10'(signed'(cmd.dy));

    always_comb begin
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        buttons_next  = buttons_reg;
        case (cmd.outcome)
            OUT_RECENTERED: begin
                cursor_x_next = centre_of(cfg.screen_width);
                cursor_y_next = centre_of(cfg.screen_height);
            end
            OUT_APPLIED: begin
                cursor_x_next = move_clamped(cursor_x_reg, delta_x, limit_of(cfg.screen_width));
                cursor_y_next = move_clamped(cursor_y_reg, delta_y, limit_of(cfg.screen_height));
                buttons_next  = cmd.buttons;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_x_reg <= COORD_BITS'(RESET_X);
            cursor_y_reg <= COORD_BITS'(RESET_Y);
            buttons_reg  <= 3'd0;
            m_valid_reg  <= 1'b0;
            outcome_reg  <= OUT_IGNORED;
        end else begin
            if (cmd_take) begin
                cursor_x_reg <= cursor_x_next;
                cursor_y_reg <= cursor_y_next;
                buttons_reg  <= buttons_next;
                outcome_reg  <= cmd.outcome;
                m_valid_reg  <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg  <= 1'b0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_cursor_x_out = OUT_COORD_BITS'(cursor_x_reg);
    assign m_cursor_y_out = OUT_COORD_BITS'(cursor_y_reg);
    assign m_buttons_out  = buttons_reg;
    assign m_outcome      = outcome_reg;

    a_take_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_take |=> m_valid_reg)
        else $error("taken command not presented");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> ($stable(cursor_x_reg) && $stable(cursor_y_reg)))
        else $error("cursor changed while result stalled");

endmodule

// ===== rtl/ps2_mouse_packet_tracker.sv =====
// top level of the ps2 mouse packet tracker
//
// the s_ channel carries one transaction per mouse byte (s_req_type 0, byte in
// s_data_byte) or a recenter request (s_req_type 1). every input transaction
// produces exactly one m_ transaction with the cursor, buttons and outcome
// after that item, in order. a front end tracks the 3-byte packet position and
// classifies each byte, a 2-entry command queue decouples it from the back end,
// which applies the add-and-clamp and holds the result register.
// an accepted transaction is written into the queue, and the back end takes it
// from there into the result register; throughput is one transaction per
// cycle while m_ready is high. when m_ready is low the result is held, the
// queue fills, and s_ready drops once two further transactions are waiting.
// reset (aresetn low, synchronous) clears the packet position, puts the cursor
// at 400,300 (limited to the coordinate range), clears the buttons and loads
// the registers with width 800, height 600, mouse disabled. configuration is
// over an apb-style port: width at 0x0, height at 0x4, enable at 0x8; the user
// must write while no transaction is in flight; the block does not enforce it.
module ps2_mouse_packet_tracker import pmt_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_BITS-1:0]  paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_req_type,
    input  logic [7:0]                s_data_byte,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [OUT_COORD_BITS-1:0] m_cursor_x_out,
    output logic [OUT_COORD_BITS-1:0] m_cursor_y_out,
    output logic [2:0]                m_buttons_out,
    output logic [2:0]                m_outcome
);

    cfg_t       cfg_reg;
    reg_index_t reg_index;
    logic       cfg_write;
    logic       accept;
    logic       queue_full;
    logic       queue_not_empty;
    logic       cmd_take;
    cmd_t       front_cmd;
    cmd_t       back_cmd;

    assign pready    = 1'b1;
    assign reg_index = reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.screen_width  <= WIDTH_RESET;
            cfg_reg.screen_height <= HEIGHT_RESET;
            cfg_reg.mouse_enable  <= 1'b0;
        end else if (cfg_write) begin
            case (reg_index)
                REG_SCREEN_WIDTH:  cfg_reg.screen_width  <= pwdata[SIZE_BITS-1:0];
                REG_SCREEN_HEIGHT: cfg_reg.screen_height <= pwdata[SIZE_BITS-1:0];
                REG_MOUSE_ENABLE:  cfg_reg.mouse_enable  <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            REG_SCREEN_WIDTH:  prdata = 32'(cfg_reg.screen_width);
            REG_SCREEN_HEIGHT: prdata = 32'(cfg_reg.screen_height);
            REG_MOUSE_ENABLE:  prdata = 32'(cfg_reg.mouse_enable);
            default:           prdata = 32'd0;
        endcase
    end

    assign s_ready = !queue_full;
    assign accept  = s_valid && s_ready;

    pmt_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .accept    (accept),
        .req_type  (s_req_type),
        .data_byte (s_data_byte),
        .cmd       (front_cmd)
    );

    pmt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_cmd  (front_cmd),
        .full      (queue_full),
        .pop       (cmd_take),
        .not_empty (queue_not_empty),
        .pop_cmd   (back_cmd)
    );

    pmt_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .cmd_valid      (queue_not_empty),
        .cmd            (back_cmd),
        .cmd_take       (cmd_take),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_cursor_x_out (m_cursor_x_out),
        .m_cursor_y_out (m_cursor_y_out),
        .m_buttons_out  (m_buttons_out),
        .m_outcome      (m_outcome)
    );

endmodule
